FILE: src/terminal_text_width_counter_assert.svh
// Assertion macros for the terminal text width counter RTL.
`ifndef TERMINAL_TEXT_WIDTH_COUNTER_ASSERT_SVH
`define TERMINAL_TEXT_WIDTH_COUNTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define TTWC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TTWC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TTWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ttwc_pkg.sv
// Shared types, constants and helper functions for the text width counter.
package ttwc_pkg;

	localparam int MaxTextBytes = 256;
	localparam int EscWindow    = 20;

	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;

	// register indexes, taken from paddr[2]
	localparam logic REG_IGNORE_ESC = 1'b0;
	localparam logic REG_COUNT_WIDE = 1'b1;

	localparam logic [7:0] ESC_CHAR  = 8'h1B;
	localparam logic [7:0] CHAR_AT   = 8'h40;
	localparam logic [7:0] CHAR_HAT  = 8'h5E;
	localparam logic [7:0] CHAR_TILDE = 8'h7E;
	localparam logic [7:0] CHAR_UC_O = 8'h4F;
	localparam logic [7:0] CHAR_UC_M = 8'h4D;
	localparam logic [7:0] CHAR_UC_A = 8'h41;
	localparam logic [7:0] CHAR_UC_Z = 8'h5A;
	localparam logic [7:0] CHAR_LC_A = 8'h61;
	localparam logic [7:0] CHAR_LC_Z = 8'h7A;

	localparam int MouseLen = 6;

	localparam logic [8:0] COUNT_MAX = 9'h1FF;

	typedef struct packed {
		logic ignore_esc;
		logic count_wide;
	} cfg_t;

	typedef struct packed {
		logic       overflowed;
		logic       malformed;
		logic [8:0] column_count;
	} scan_result_t;

	function automatic logic is_wide(input logic [20:0] cp);
		return (cp >= 21'h02600 && cp <= 21'h027BF) ||
		       (cp >= 21'h1F300 && cp <= 21'h1F64F) ||
		       (cp >= 21'h1F680 && cp <= 21'h1F6FF) ||
		       (cp >= 21'h1F900 && cp <= 21'h1F9FF);
	endfunction

	// saturating column add
	function automatic logic [8:0] sat_add(input logic [8:0] a, input logic [1:0] inc);
		logic [9:0] sum;
		sum = {1'b0, a} + {8'b0, inc};
		return sum[9] ? COUNT_MAX : sum[8:0];
	endfunction

	// terminator of an escape sequence ('M' handled apart)
	function automatic logic is_esc_term(input logic [7:0] c);
		return (c == CHAR_AT) || (c == CHAR_HAT) || (c == CHAR_TILDE) ||
		       (c >= CHAR_UC_A && c <= CHAR_UC_Z && c != CHAR_UC_O && c != CHAR_UC_M) ||
		       (c >= CHAR_LC_A && c <= CHAR_LC_Z);
	endfunction

endpackage

FILE: src/ttwc_cfg_regs.sv
// APB configuration registers: ignore_esc and count_wide.
module ttwc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ttwc_pkg::ApbAddrW-1:0] paddr,
	input  logic [ttwc_pkg::ApbDataW-1:0] pwdata,
	output logic [ttwc_pkg::ApbDataW-1:0] prdata,
	output logic                          pready,
	output ttwc_pkg::cfg_t                cfg
);

	logic ignore_esc_q;
	logic count_wide_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_esc_q <= 1'b0;
			count_wide_q <= 1'b0;
		end else if (wr_en) begin
			if (paddr[2] == ttwc_pkg::REG_IGNORE_ESC) begin
				ignore_esc_q <= pwdata[0];
			end else begin
				count_wide_q <= pwdata[0];
			end
		end
	end

	// paddr[1:0] select nothing: registers sit on word boundaries
	always_comb begin
		prdata = '0;
		if (paddr[2] == ttwc_pkg::REG_COUNT_WIDE) begin
			prdata[0] = count_wide_q;
		end else begin
			prdata[0] = ignore_esc_q;
		end
	end

	assign cfg.ignore_esc = ignore_esc_q;
	assign cfg.count_wide = count_wide_q;

endmodule

FILE: src/ttwc_text_buf.sv
// Text byte store: load side bookkeeping and the byte memory with a registered read port.
module ttwc_text_buf #(
	parameter int MAX_TEXT_BYTES = ttwc_pkg::MaxTextBytes
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,
	input  logic                                 s_tlast,
	input  logic                                 busy,
	input  logic [$clog2(MAX_TEXT_BYTES)-1:0]    rd_addr,
	output logic [7:0]                           rd_data,
	output logic                                 start,
	output logic [$clog2(MAX_TEXT_BYTES+1)-1:0]  start_end,
	output logic                                 start_ovf
);

	localparam int AW = $clog2(MAX_TEXT_BYTES);
	localparam int CW = $clog2(MAX_TEXT_BYTES + 1);

	logic [7:0]    mem [MAX_TEXT_BYTES];
	logic [7:0]    rd_data_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] end_q;
	logic          zero_seen_q;
	logic          ovf_q;

	logic          acc;
	logic          wr_en;
	logic [CW-1:0] fill_inc;
	logic [CW-1:0] end_nx;

	assign s_tready = ~busy;
	assign acc      = s_tvalid & s_tready;
	assign wr_en    = acc & (fill_q != CW'(MAX_TEXT_BYTES));
	assign fill_inc = fill_q + CW'(1);

	// end of string: first zero byte, else the fill level
	always_comb begin
		end_nx = end_q;
		if (!zero_seen_q && wr_en) begin
			end_nx = (s_tdata == 8'h00) ? fill_q : fill_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= s_tdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			end_q       <= '0;
			zero_seen_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (acc) begin
			if (s_tlast) begin
				fill_q      <= '0;
				end_q       <= '0;
				zero_seen_q <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				end_q <= end_nx;
				if (wr_en) begin
					fill_q <= fill_inc;
					if (s_tdata == 8'h00) begin
						zero_seen_q <= 1'b1;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign rd_data   = rd_data_q;
	assign start     = acc & s_tlast;
	assign start_end = end_nx;
	assign start_ovf = ovf_q | ~wr_en;

endmodule

FILE: src/ttwc_scan.sv
// Scan sequencer: walks the stored string, skips escapes when ignore_esc is set, decodes UTF-8, holds the result word.
module ttwc_scan #(
	parameter int MAX_TEXT_BYTES = ttwc_pkg::MaxTextBytes,
	parameter int ESC_WINDOW     = ttwc_pkg::EscWindow
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ttwc_pkg::cfg_t                       cfg,
	input  logic                                 start,
	input  logic [$clog2(MAX_TEXT_BYTES+1)-1:0]  start_end,
	input  logic                                 start_ovf,
	output logic [$clog2(MAX_TEXT_BYTES)-1:0]    rd_addr,
	input  logic [7:0]                           rd_data,
	output logic                                 busy,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output ttwc_pkg::scan_result_t               result
);

	localparam int AW = $clog2(MAX_TEXT_BYTES);
	localparam int CW = $clog2(MAX_TEXT_BYTES + 1);
	localparam int WW = $clog2(ESC_WINDOW + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_LEAD  = 3'd2;
	localparam logic [2:0] ST_CONT  = 3'd3;
	localparam logic [2:0] ST_ESC   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [CW-1:0] end_q, end_d;
	logic          ovf_q, ovf_d;
	logic          bad_q, bad_d;
	logic [8:0]    width_q, width_d;
	logic [WW-1:0] off_q, off_d;
	logic [WW-1:0] win_q, win_d;
	logic [1:0]    need_q, need_d;
	logic [2:0]    len_q, len_d;
	logic [20:0]   cp_q, cp_d;

	logic                   out_valid_q;
	ttwc_pkg::scan_result_t out_q;
	logic                   out_free;

	logic [CW-1:0] remain;
	logic [CW-1:0] addr_w;
	logic [WW-1:0] next_off;
	logic [20:0]   cp_cat;
	logic [20:0]   cp_min;
	logic [1:0]    inc;
	logic [2:0]    lead_len;
	logic [20:0]   lead_bits;

	assign remain   = end_q - pos_q;
	assign next_off = off_q + WW'(1);
	assign cp_cat   = {cp_q[14:0], rd_data[5:0]};
	assign out_free = ~out_valid_q | m_tready;
	assign inc      = (cfg.count_wide && ttwc_pkg::is_wide(cp_cat)) ? 2'd2 : 2'd1;

	always_comb begin
		case (len_q)
			3'd2:    cp_min = 21'h00080;
			3'd3:    cp_min = 21'h00800;
			default: cp_min = 21'h10000;
		endcase
	end

	always_comb begin
		lead_len  = 3'd0;
		lead_bits = '0;
		if (rd_data inside {[8'hC2:8'hDF]}) begin
			lead_len  = 3'd2;
			lead_bits = {16'b0, rd_data[4:0]};
		end else if (rd_data inside {[8'hE0:8'hEF]}) begin
			lead_len  = 3'd3;
			lead_bits = {17'b0, rd_data[3:0]};
		end else if (rd_data inside {[8'hF0:8'hF4]}) begin
			lead_len  = 3'd4;
			lead_bits = {18'b0, rd_data[2:0]};
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		end_d   = end_q;
		ovf_d   = ovf_q;
		bad_d   = bad_q;
		width_d = width_q;
		off_d   = off_q;
		win_d   = win_q;
		need_d  = need_q;
		len_d   = len_q;
		cp_d    = cp_q;
		addr_w  = pos_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					pos_d   = '0;
					end_d   = start_end;
					ovf_d   = start_ovf;
					bad_d   = 1'b0;
					width_d = '0;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = (pos_q >= end_q) ? ST_DONE : ST_LEAD;
			end
			ST_LEAD: begin
				addr_w = pos_q + CW'(1);
				if (cfg.ignore_esc && rd_data == ttwc_pkg::ESC_CHAR) begin
					win_d = (int'(remain) < ESC_WINDOW) ? WW'(remain) : WW'(ESC_WINDOW);
					if (win_d > WW'(1)) begin
						off_d   = WW'(1);
						state_d = ST_ESC;
					end else begin
						width_d = ttwc_pkg::sat_add(width_q, 2'd1);
						pos_d   = pos_q + CW'(1);
						state_d = ST_FETCH;
					end
				end else if (rd_data[7] == 1'b0) begin
					width_d = ttwc_pkg::sat_add(width_q, 2'd1);
					pos_d   = pos_q + CW'(1);
					state_d = ST_FETCH;
				end else if (lead_len == 3'd0 || remain < CW'(lead_len)) begin
					// bad lead byte, or sequence cut by the end of the string
					bad_d   = 1'b1;
					state_d = ST_DONE;
				end else begin
					len_d   = lead_len;
					need_d  = 2'(lead_len - 3'd1);
					cp_d    = lead_bits;
					off_d   = WW'(1);
					state_d = ST_CONT;
				end
			end
			ST_CONT: begin
				addr_w = pos_q + CW'(next_off);
				cp_d   = cp_cat;
				if (rd_data[7:6] != 2'b10) begin
					bad_d   = 1'b1;
					state_d = ST_DONE;
				end else if (need_q == 2'd1) begin
					// overlong, surrogate or beyond the code space
					if (cp_cat < cp_min || cp_cat > 21'h10FFFF ||
					    (cp_cat >= 21'h0D800 && cp_cat <= 21'h0DFFF)) begin
						bad_d   = 1'b1;
						state_d = ST_DONE;
					end else begin
						width_d = ttwc_pkg::sat_add(width_q, inc);
						pos_d   = pos_q + CW'(len_q);
						state_d = ST_FETCH;
					end
				end else begin
					need_d = need_q - 2'd1;
					off_d  = next_off;
				end
			end
			ST_ESC: begin
				addr_w = pos_q + CW'(next_off);
				if (ttwc_pkg::is_esc_term(rd_data)) begin
					pos_d   = pos_q + CW'(off_q) + CW'(1);
					state_d = ST_FETCH;
				end else if (rd_data == ttwc_pkg::CHAR_UC_M &&
				             win_q >= WW'(ttwc_pkg::MouseLen)) begin
					pos_d   = pos_q + CW'(ttwc_pkg::MouseLen);
					state_d = ST_FETCH;
				end else if (rd_data != ttwc_pkg::CHAR_UC_M && next_off < win_q) begin
					off_d = next_off;
				end else begin
					// no sequence: the ESC is a plain one-column char
					width_d = ttwc_pkg::sat_add(width_q, 2'd1);
					pos_d   = pos_q + CW'(1);
					state_d = ST_FETCH;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			end_q   <= '0;
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
			width_q <= '0;
			off_q   <= '0;
			win_q   <= '0;
			need_q  <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			end_q   <= end_d;
			ovf_q   <= ovf_d;
			bad_q   <= bad_d;
			width_q <= width_d;
			off_q   <= off_d;
			win_q   <= win_d;
			need_q  <= need_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		cp_q <= cp_d;
	end

	// result word holds until taken; meanwhile the load side runs whenever the scan is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.column_count <= width_q;
			out_q.malformed    <= bad_q;
			out_q.overflowed   <= ovf_q;
		end
	end

	assign rd_addr  = addr_w[AW-1:0];
	assign busy     = (state_q != ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign result   = out_q;

	`include "terminal_text_width_counter_assert.svh"

	`TTWC_ASSERT_ALWAYS(a_pos_in_string, pos_q <= end_q, "scan cursor passed end of string")
	`TTWC_ASSERT_IMP(a_start_when_idle, start, state_q == ST_IDLE, "string started during scan")
	`TTWC_ASSERT_IMP(a_esc_in_window, state_q == ST_ESC, off_q < win_q && win_q <= remain,
		"escape lookahead outside its window")
	`TTWC_ASSERT_IMP(a_cont_in_string, state_q == ST_CONT,
		need_q != 2'd0 && CW'(len_q) <= remain, "continuation read outside character")

endmodule

FILE: src/terminal_text_width_counter.sv
// Top level of the terminal text width counter: byte store, scan sequencer, config registers.
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+-------------------------------------------------
//  s_        | in  | tvalid/tready      | tdata[7:0] text_byte, tlast last_byte
//  m_        | out | tvalid/tready      | tdata[8:0] column_count, [9] malformed, [10] overflowed
//  apb       | in  | psel/penable/pready| 0x0 ignore_esc, 0x4 count_wide
//
// Load: one byte per cycle. On the last byte the scan runs from the memory's single read
// port: a fetch and a lead step per char, then continuation steps per multi-byte char or
// lookahead steps per escape, then an end check and result write. s_tready is low during
// the scan. Async reset clears all control state; the byte memory is not cleared (bytes past
// the fill level are never used). A result waiting on m_tready stalls the next scan's end.
module terminal_text_width_counter #(
	parameter int MAX_TEXT_BYTES = ttwc_pkg::MaxTextBytes,
	parameter int ESC_WINDOW     = ttwc_pkg::EscWindow
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] text_byte
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [8:0] column_count, [9] malformed,
	                                                 // [10] overflowed, [15:11] zero
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ttwc_pkg::ApbAddrW-1:0] paddr,
	input  logic [ttwc_pkg::ApbDataW-1:0] pwdata,
	output logic [ttwc_pkg::ApbDataW-1:0] prdata,
	output logic                          pready
);

	localparam int AW = $clog2(MAX_TEXT_BYTES);
	localparam int CW = $clog2(MAX_TEXT_BYTES + 1);

	ttwc_pkg::cfg_t         cfg;
	ttwc_pkg::scan_result_t result;
	logic                   busy;
	logic [AW-1:0]          rd_addr;
	logic [7:0]             rd_data;
	logic                   start;
	logic [CW-1:0]          start_end;
	logic                   start_ovf;

	ttwc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttwc_text_buf #(
		.MAX_TEXT_BYTES (MAX_TEXT_BYTES)
	) u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.busy      (busy),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.start     (start),
		.start_end (start_end),
		.start_ovf (start_ovf)
	);

	ttwc_scan #(
		.MAX_TEXT_BYTES (MAX_TEXT_BYTES),
		.ESC_WINDOW     (ESC_WINDOW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.start_end (start_end),
		.start_ovf (start_ovf),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.busy      (busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result    (result)
	);

	assign m_tdata = {5'b0, result.overflowed, result.malformed, result.column_count};

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the terminal text width counter: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int CycleLimit  = 1000000;
	localparam int SettleCycles = 16;
	localparam int PhaseWords   = 40;

	typedef struct packed {
		logic       is_last;
		logic [7:0] data;
	} text_word_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata  = '0;   // [7:0] text_byte
	logic                          s_tlast  = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [15:0]                   m_tdata;  // [8:0] column_count, [9] malformed, [10] overflowed
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [ttwc_pkg::ApbAddrW-1:0] paddr    = '0;
	logic [ttwc_pkg::ApbDataW-1:0] pwdata   = '0;
	logic [ttwc_pkg::ApbDataW-1:0] prdata;
	logic                          pready;

	terminal_text_width_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stimulus and scoreboard state
	text_word_t             text_words[$];
	text_word_t             next_word;
	logic [7:0]             draft[$];
	ttwc_pkg::scan_result_t expected_widths[$];
	int                     words_queued = 0;
	int                     words_taken  = 0;
	int                     tx_idle_pct  = 0;
	int                     rx_idle_pct  = 0;
	int                     error_count  = 0;
	int                     cycle_count  = 0;
	logic                   s_fire       = 1'b0;

	// shadow of the block: byte store, fill level, drop flag, settings
	logic [7:0]   text_buf[0:ttwc_pkg::MaxTextBytes-1];
	int unsigned  fill_level = 0;
	bit           bytes_dropped = 0;
	bit           skip_esc = 0;
	bit           wide_on = 0;

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	// length of an escape sequence starting at pos, 0 when there is none
	function automatic int unsigned esc_span(input int unsigned pos, input int unsigned stop);
		int unsigned window;
		int unsigned k;
		logic [7:0]  c;
		if (pos >= stop || text_buf[pos] != ttwc_pkg::ESC_CHAR)
			return 0;
		window = (stop - pos < ttwc_pkg::EscWindow) ? stop - pos : ttwc_pkg::EscWindow;
		for (k = 1; k < window; k++) begin
			c = text_buf[pos + k];
			if (c == ttwc_pkg::CHAR_AT || c == ttwc_pkg::CHAR_HAT || c == ttwc_pkg::CHAR_TILDE)
				return k + 1;
			if (c == ttwc_pkg::CHAR_UC_M)
				return (window >= ttwc_pkg::MouseLen) ? ttwc_pkg::MouseLen : 0;
			if (c >= ttwc_pkg::CHAR_UC_A && c <= ttwc_pkg::CHAR_UC_Z && c != ttwc_pkg::CHAR_UC_O)
				return k + 1;
			if (c >= ttwc_pkg::CHAR_LC_A && c <= ttwc_pkg::CHAR_LC_Z)
				return k + 1;
		end
		return 0;
	endfunction

	// byte length of the UTF-8 char at pos, 0 when malformed
	function automatic int unsigned utf8_span(input int unsigned pos, input int unsigned stop,
			output logic [20:0] cp);
		logic [7:0]  lead;
		logic [7:0]  b;
		int unsigned len;
		int unsigned i;
		logic [31:0] val;
		logic [31:0] lowest;
		lead = text_buf[pos];
		cp = '0;
		if (lead < 8'h80) begin
			cp = {13'b0, lead};
			return 1;
		end
		if (lead >= 8'hC2 && lead <= 8'hDF) begin
			len = 2; val = {27'b0, lead[4:0]}; lowest = 32'h80;
		end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
			len = 3; val = {28'b0, lead[3:0]}; lowest = 32'h800;
		end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
			len = 4; val = {29'b0, lead[2:0]}; lowest = 32'h10000;
		end else begin
			return 0;
		end
		if (stop - pos < len)
			return 0;
		for (i = 1; i < len; i++) begin
			b = text_buf[pos + i];
			if (b[7:6] != 2'b10)
				return 0;
			val = (val << 6) | {26'b0, b[5:0]};
		end
		if (val < lowest || val > 32'h10FFFF || (val >= 32'hD800 && val <= 32'hDFFF))
			return 0;
		cp = val[20:0];
		return len;
	endfunction

	function automatic bit double_column(input logic [20:0] cp);
		return (cp >= 21'h02600 && cp <= 21'h027BF) || (cp >= 21'h1F300 && cp <= 21'h1F64F) ||
		       (cp >= 21'h1F680 && cp <= 21'h1F6FF) || (cp >= 21'h1F900 && cp <= 21'h1F9FF);
	endfunction

	function automatic ttwc_pkg::scan_result_t measure_text();
		int unsigned            stop;
		int unsigned            pos;
		int unsigned            n;
		int unsigned            cols;
		logic [20:0]            cp;
		bit                     found;
		bit                     bad;
		ttwc_pkg::scan_result_t r;
		stop = 0;
		while (stop < fill_level && text_buf[stop] != 8'h00)
			stop++;
		pos = 0;
		cols = 0;
		bad = 0;
		while (pos < stop) begin
			found = 0;
			if (skip_esc) begin
				n = esc_span(pos, stop);
				found = (n > 0);
				while (n > 0 && pos < stop) begin
					pos += n;
					n = esc_span(pos, stop);
				end
			end
			if (pos < stop) begin
				n = utf8_span(pos, stop, cp);
				if (n > 0) begin
					found = 1;
					pos += n;
					cols += (wide_on && double_column(cp)) ? 2 : 1;
					if (cols > 511)
						cols = 511;
				end
			end
			if (!found) begin
				bad = 1;
				break;
			end
		end
		r.column_count = cols[8:0];
		r.malformed    = bad;
		r.overflowed   = bytes_dropped;
		return r;
	endfunction

	task automatic take_byte(input logic [7:0] b, input logic is_last);
		if (fill_level < ttwc_pkg::MaxTextBytes)
			text_buf[fill_level++] = b;
		else
			bytes_dropped = 1;
		if (is_last) begin
			expected_widths.push_back(measure_text());
			fill_level = 0;
			bytes_dropped = 0;
		end
	endtask

	// word driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (text_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_word = text_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_word.data;
				s_tlast  <= next_word.is_last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// monitor and scoreboard
	always @(posedge clk) begin
		ttwc_pkg::scan_result_t got;
		ttwc_pkg::scan_result_t want;
		s_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				words_taken++;
				take_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				got = ttwc_pkg::scan_result_t'(m_tdata[10:0]);
				if (expected_widths.size() == 0) begin
					flag_mismatch($sformatf("unexpected word %h", m_tdata));
				end else begin
					want = expected_widths.pop_front();
					if (got.column_count !== want.column_count || got.malformed !== want.malformed ||
					    got.overflowed !== want.overflowed)
						flag_mismatch($sformatf("columns %0d/%0d malformed %b/%b overflowed %b/%b",
							got.column_count, want.column_count, got.malformed, want.malformed,
							got.overflowed, want.overflowed));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (words_taken != words_queued || expected_widths.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_access(input logic idx, input logic wr, input logic val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(ttwc_pkg::ApbDataW-1){1'b0}}, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (!wr && prdata !== {{(ttwc_pkg::ApbDataW-1){1'b0}}, val})
			flag_mismatch($sformatf("register %0d reads %h, wrote %b", idx, prdata, val));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input bit esc_val, input bit wide_val);
		wait_drained();
		repeat (SettleCycles) @(negedge clk);
		apb_access(ttwc_pkg::REG_IGNORE_ESC, 1'b1, esc_val);
		skip_esc = esc_val;
		apb_access(ttwc_pkg::REG_IGNORE_ESC, 1'b0, esc_val);
		apb_access(ttwc_pkg::REG_COUNT_WIDE, 1'b1, wide_val);
		wide_on = wide_val;
		apb_access(ttwc_pkg::REG_COUNT_WIDE, 1'b0, wide_val);
	endtask

	// string building
	task automatic send_text();
		text_word_t w;
		foreach (draft[i]) begin
			w.data    = draft[i];
			w.is_last = (i == draft.size() - 1);
			text_words.push_back(w);
		end
		words_queued += draft.size();
		draft.delete();
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endtask

	// n bytes, most significant first
	task automatic put_bytes(input logic [31:0] seq, input int n);
		for (int i = n - 1; i >= 0; i--)
			draft.push_back(seq[8*i +: 8]);
	endtask

	task automatic put_cp(input logic [20:0] cp);
		if (cp < 21'h80)
			draft.push_back(cp[7:0]);
		else if (cp < 21'h800)
			put_bytes({16'b0, 3'b110, cp[10:6], 2'b10, cp[5:0]}, 2);
		else if (cp < 21'h10000)
			put_bytes({8'b0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]}, 3);
		else
			put_bytes({5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]}, 4);
	endtask

	task automatic put_escape();
		string      params;
		logic [7:0] term;
		params = "0123456789;?O";
		draft.push_back(ttwc_pkg::ESC_CHAR);
		if ($urandom_range(3) != 0)
			draft.push_back("[");
		repeat ($urandom_range(6))
			draft.push_back(params[$urandom_range(params.len() - 1)]);
		case ($urandom_range(3))
			0: term = ($urandom_range(2) == 0) ? ttwc_pkg::CHAR_AT :
			          ($urandom_range(1) == 0) ? ttwc_pkg::CHAR_HAT : ttwc_pkg::CHAR_TILDE;
			1: term = ttwc_pkg::CHAR_LC_A + 8'($urandom_range(25));
			default: begin
				term = ttwc_pkg::CHAR_UC_O;
				while (term == ttwc_pkg::CHAR_UC_O || term == ttwc_pkg::CHAR_UC_M)
					term = ttwc_pkg::CHAR_UC_A + 8'($urandom_range(25));
			end
		endcase
		draft.push_back(term);
	endtask

	task automatic put_random_char();
		case ($urandom_range(5))
			0: put_cp(21'($urandom_range(21'h7FF, 21'h80)));
			1: put_cp(21'($urandom_range(21'hD7FF, 21'h800)));
			2: put_cp(21'($urandom_range(21'h27BF, 21'h2600)));
			3: put_cp(21'($urandom_range(21'h1F9FF, 21'h1F300)));
			4: put_cp(21'($urandom_range(21'h10FFFF, 21'h10000)));
			default: put_cp(21'($urandom_range(21'hFFFF, 21'hE000)));
		endcase
	endtask

	task automatic build_random_text();
		int units;
		int sel;
		units = ($urandom_range(99) < 3) ? $urandom_range(300, 200) : $urandom_range(12, 1);
		repeat (units) begin
			sel = $urandom_range(99);
			if (sel < 40)
				draft.push_back(8'($urandom_range(8'h7E, 8'h20)));
			else if (sel < 62)
				put_random_char();
			else if (sel < 78)
				put_escape();
			else if (sel < 84) begin
				put_str("\033[M");
				repeat (3) draft.push_back(8'($urandom_range(255)));
			end else if (sel < 90) begin
				draft.push_back(ttwc_pkg::ESC_CHAR);
				repeat ($urandom_range(24, 1)) draft.push_back("0" + 8'($urandom_range(9)));
			end else if (sel < 95)
				draft.push_back(8'($urandom_range(255)));
			else
				put_cp(21'($urandom_range(21'h1FFFFF)));
		end
		send_text();
	endtask

	task automatic run_directed(input bit with_long);
		put_str("A"); send_text();
		draft.push_back(8'h00); send_text();
		put_str("AB"); draft.push_back(8'h00); put_str("CD"); send_text();
		// code point edges, including the ends of every wide range
		put_cp(21'h7F); put_cp(21'h80); put_cp(21'h7FF); put_cp(21'h800); put_cp(21'h25FF);
		put_cp(21'h2600); put_cp(21'h27BF); put_cp(21'h27C0); put_cp(21'hFFFF);
		put_cp(21'h10000); send_text();
		put_cp(21'h1F2FF); put_cp(21'h1F300); put_cp(21'h1F64F); put_cp(21'h1F650);
		put_cp(21'h1F680); put_cp(21'h1F6FF); put_cp(21'h1F700); put_cp(21'h1F8FF);
		put_cp(21'h1F900); put_cp(21'h1F9FF); put_cp(21'h1FA00); put_cp(21'h10FFFF);
		send_text();
		// malformed: stray continuation, bad leads, missing or cut continuation,
		// overlong forms, surrogate, above the last code point
		put_str("x"); put_bytes(32'h80, 1); put_str("y"); send_text();
		put_str("x"); put_bytes(32'hC080, 2); send_text();
		put_bytes(32'hC1BF, 2); send_text();
		put_str("x"); put_bytes(32'hF5808080, 4); send_text();
		put_str("xy"); put_bytes(32'hFF, 1); send_text();
		put_bytes(32'hC341, 2); send_text();
		put_str("x"); put_bytes(32'hE298, 2); send_text();
		put_bytes(32'hE08080, 3); send_text();
		put_bytes(32'hF08FBFBF, 4); send_text();
		put_str("x"); put_bytes(32'hEDA080, 3); send_text();
		put_bytes(32'hF4908080, 4); send_text();
		// escapes
		put_str("\033[31mred\033[0m"); send_text();
		put_str("\033[@\033^\033~"); put_str("\033OP"); send_text();
		put_str("\033[M"); put_bytes(32'h20FF21, 3); put_str("z"); send_text();
		put_str("\033[Mab"); send_text();
		put_str("\033123456789012345678m"); put_str("\033123456789012345678901234");
		send_text();
		put_str("\0331234567890123456789m"); send_text();
		put_str("\033[1m\033[2J\033[Hok"); send_text();
		put_str("\033[m"); put_bytes(32'h80, 1); send_text();
		put_str("\033[3"); draft.push_back(8'h00); put_str("m"); send_text();
		put_str("a\033"); send_text();
		if (with_long) begin
			// full store, then strings that overflow with the bytes past the store dropped
			repeat (ttwc_pkg::MaxTextBytes) draft.push_back("a"); send_text();
			repeat (300) draft.push_back("b"); send_text();
			repeat (90) put_cp(21'h2603); send_text();
		end
	endtask

	initial begin
		int phase;
		int target;
		int strings;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 6;
		rx_idle_pct = 70;
		set_config(0, 0); run_directed(1'b0);
		set_config(1, 1); run_directed(1'b1);
		set_config(1, 0); run_directed(1'b0);
		set_config(0, 1); run_directed(1'b0);
		strings = 0;
		for (phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				tx_idle_pct = 70;
				rx_idle_pct = 6;
			end else if (phase == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_config(1'($urandom_range(1)), 1'($urandom_range(1)));
			target = words_queued + PhaseWords;
			while (words_queued < target) begin
				build_random_text();
				strings++;
				// hold the sender now and then until the results are all back
				if (strings % 20 == 0)
					wait_drained();
			end
		end
		wait_drained();
		repeat (64) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
